### sv/lbfg_pkg.sv
// lbfg_pkg: field widths, payload and configuration types, control word
// and microcode table of the load based frequency governor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lbfg_pkg;

    localparam int LOAD_W   = 29;
    localparam int LOAD_EW  = LOAD_W + (LOAD_W % 2);
    localparam int FREQ_W   = 22;
    localparam int PCT_W    = 7;
    localparam int TGT_W    = 23;
    localparam int REASON_W = 3;
    localparam int PROD_W   = PCT_W + FREQ_W;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [TGT_W-1:0] TGT_MAX = {TGT_W{1'b1}};

    typedef enum logic [REASON_W-1:0] {
        RSN_BAND  = 3'd0,
        RSN_HIGH  = 3'd1,
        RSN_JUMP  = 3'd2,
        RSN_CALC  = 3'd3,
        RSN_LIMIT = 3'd4
    } t_reason;

    typedef enum logic [2:0] {
        REG_MAX_FREQ  = 3'd0,
        REG_MIN_FREQ  = 3'd1,
        REG_BIAS_EN   = 3'd2,
        REG_HIGH_PCT  = 3'd3,
        REG_JUMP_MRG  = 3'd4,
        REG_BAND_LO   = 3'd5,
        REG_BAND_HI   = 3'd6,
        REG_TGT_PCT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [LOAD_W-1:0] load_figure;
        logic [FREQ_W-1:0] cur_freq;
    } t_in;

    typedef struct packed {
        logic                request_valid;
        logic [TGT_W-1:0]    target_freq;
        logic                via_bias;
        logic [LOAD_W-1:0]   average_load;
        logic [REASON_W-1:0] reason;
    } t_out;

    typedef struct packed {
        logic [FREQ_W-1:0] max_freq;
        logic [FREQ_W-1:0] min_freq;
        logic              bias_enable;
        logic [PCT_W-1:0]  high_load_pct;
        logic [LOAD_W-1:0] jump_margin;
        logic [PCT_W-1:0]  band_low_pct;
        logic [PCT_W-1:0]  band_high_pct;
        logic [PCT_W-1:0]  target_pct;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_UPDATE    = 4'd2,
        OP_AVG_START = 4'd3,
        OP_BAND_LO   = 4'd4,
        OP_BAND_HI   = 4'd5,
        OP_DECIDE    = 4'd6,
        OP_QUOT      = 4'd7,
        OP_EMIT      = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_NO_IN    = 3'd1,
        C_DIV_BUSY = 3'd2,
        C_NOT_CALC = 3'd3,
        C_OUT_FULL = 3'd4
    } t_cond;

    localparam int PROG_LEN = 11;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] addr;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic not_calc;
        logic out_full;
    } t_stat;

    function automatic t_ctl ucode(input logic [PC_W-1:0] pc);
        t_ctl w;
        w = '{op: OP_NOP, cond: C_NEXT, addr: '0};
        unique case (pc)
            4'd0:    w = '{op: OP_ACCEPT,    cond: C_NO_IN,    addr: 4'd0};
            4'd1:    w = '{op: OP_UPDATE,    cond: C_NEXT,     addr: 4'd0};
            4'd2:    w = '{op: OP_AVG_START, cond: C_NEXT,     addr: 4'd0};
            4'd3:    w = '{op: OP_BAND_LO,   cond: C_NEXT,     addr: 4'd0};
            4'd4:    w = '{op: OP_BAND_HI,   cond: C_NEXT,     addr: 4'd0};
            4'd5:    w = '{op: OP_NOP,       cond: C_DIV_BUSY, addr: 4'd5};
            4'd6:    w = '{op: OP_DECIDE,    cond: C_NEXT,     addr: 4'd0};
            4'd7:    w = '{op: OP_NOP,       cond: C_NOT_CALC, addr: 4'd10};
            4'd8:    w = '{op: OP_NOP,       cond: C_DIV_BUSY, addr: 4'd8};
            4'd9:    w = '{op: OP_QUOT,      cond: C_NEXT,     addr: 4'd0};
            4'd10:   w = '{op: OP_EMIT,      cond: C_OUT_FULL, addr: 4'd10};
            default: w = '{op: OP_NOP,       cond: C_NEXT,     addr: 4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/load_based_frequency_governor_unit.sv
// load_based_frequency_governor_unit: top level with configuration
// registers and apb port; depends on lbfg_pkg, lbfg_seq and lbfg_dp
`timescale 1ns / 1ps
`default_nettype none

// One load sample in, one decision out. A short microprogram steps a plain
// datapath: the sample is pushed into a ring of the last HISTORY_DEPTH load
// figures (kept in a ram, with a wrap flag so no clearing pass is needed
// after reset), the running sum is divided by the depth for the moving
// average, thresholds are checked with one shared multiplier, and where a
// target is computed the load figure is divided by target_pct. Both
// divisions use one divider retiring two quotient bits per cycle. An item
// runs through the steps of the program, one divider run for the moving
// average and, when a target is computed, a second divider run for the
// target division; the next item is accepted once the program returns
// to its first step. The output register lets a new item be accepted
// while the previous result waits to be taken.
module load_based_frequency_governor_unit #(
    parameter int HISTORY_DEPTH = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire lbfg_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output lbfg_pkg::t_out                         o_out_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lbfg_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [lbfg_pkg::PDATA_W-1:0]      pwdata,
    output logic      [lbfg_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);
    import lbfg_pkg::*;

    t_cfg     r_cfg;
    t_ctl     ctl;
    t_stat    stat;
    t_reg_idx idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_freq      <= FREQ_W'(1704000);
            r_cfg.min_freq      <= FREQ_W'(132000);
            r_cfg.bias_enable   <= 1'b0;
            r_cfg.high_load_pct <= PCT_W'(95);
            r_cfg.jump_margin   <= LOAD_W'(9000000);
            r_cfg.band_low_pct  <= PCT_W'(60);
            r_cfg.band_high_pct <= PCT_W'(80);
            r_cfg.target_pct    <= PCT_W'(65);
        end else if (wr) begin
            unique case (idx)
                REG_MAX_FREQ: r_cfg.max_freq      <= pwdata[FREQ_W-1:0];
                REG_MIN_FREQ: r_cfg.min_freq      <= pwdata[FREQ_W-1:0];
                REG_BIAS_EN:  r_cfg.bias_enable   <= pwdata[0];
                REG_HIGH_PCT: r_cfg.high_load_pct <= pwdata[PCT_W-1:0];
                REG_JUMP_MRG: r_cfg.jump_margin   <= pwdata[LOAD_W-1:0];
                REG_BAND_LO:  r_cfg.band_low_pct  <= pwdata[PCT_W-1:0];
                REG_BAND_HI:  r_cfg.band_high_pct <= pwdata[PCT_W-1:0];
                REG_TGT_PCT:  r_cfg.target_pct    <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MAX_FREQ: prdata = PDATA_W'(r_cfg.max_freq);
            REG_MIN_FREQ: prdata = PDATA_W'(r_cfg.min_freq);
            REG_BIAS_EN:  prdata = PDATA_W'(r_cfg.bias_enable);
            REG_HIGH_PCT: prdata = PDATA_W'(r_cfg.high_load_pct);
            REG_JUMP_MRG: prdata = PDATA_W'(r_cfg.jump_margin);
            REG_BAND_LO:  prdata = PDATA_W'(r_cfg.band_low_pct);
            REG_BAND_HI:  prdata = PDATA_W'(r_cfg.band_high_pct);
            REG_TGT_PCT:  prdata = PDATA_W'(r_cfg.target_pct);
            default:      prdata = '0;
        endcase
    end

    assign o_in_ready = (ctl.op == OP_ACCEPT);

    lbfg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    lbfg_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

### sv/lbfg_ram.sv
// lbfg_ram: generic single write port, single read port ram with
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lbfg_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/lbfg_seq.sv
// lbfg_seq: step counter and microcode fetch with conditional jumps
// depends on lbfg_pkg (control word, status and microcode table)
`timescale 1ns / 1ps
`default_nettype none

module lbfg_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lbfg_pkg::t_stat i_stat,
    output lbfg_pkg::t_ctl      o_ctl
);
    import lbfg_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            jump;

    assign o_ctl = ucode(r_pc);

    always_comb begin
        unique case (o_ctl.cond)
            C_NEXT:     jump = 1'b0;
            C_NO_IN:    jump = !i_stat.in_valid;
            C_DIV_BUSY: jump = i_stat.div_busy;
            C_NOT_CALC: jump = i_stat.not_calc;
            C_OUT_FULL: jump = i_stat.out_full;
            default:    jump = 1'b0;
        endcase
        if (jump) begin
            n_pc = o_ctl.addr;
        end else if (r_pc == PC_W'(PROG_LEN - 1)) begin
            n_pc = '0;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

### sv/lbfg_dp.sv
// lbfg_dp: datapath of the governor: history ring, running sum, shared
// multiplier, two-bit-per-cycle divider, decision and output register
// depends on lbfg_pkg and lbfg_ram
`timescale 1ns / 1ps
`default_nettype none

module lbfg_dp #(
    parameter int HISTORY_DEPTH = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lbfg_pkg::t_ctl i_ctl,
    input  wire lbfg_pkg::t_cfg i_cfg,
    input  wire logic           i_in_valid,
    input  wire lbfg_pkg::t_in  i_in_data,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output lbfg_pkg::t_out      o_out_data,
    output lbfg_pkg::t_stat     o_stat
);
    import lbfg_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = LOAD_W + $clog2(HISTORY_DEPTH);
    localparam int DVD_W = SUM_W + (SUM_W % 2);
    localparam int DVS_W = PCT_W;
    localparam int CNT_W = $clog2(DVD_W / 2 + 1);

    logic [LOAD_W-1:0] r_load;
    logic [FREQ_W-1:0] r_cur;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_full;
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    logic              r_hi;
    logic              r_blo;
    logic              r_bhi;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic [LOAD_W-1:0] r_avg;
    t_reason           r_reason;
    logic [TGT_W-1:0]  r_target;
    logic              r_out_valid;
    t_out              r_out;

    logic [LOAD_W-1:0] ram_rdata;
    logic [LOAD_W-1:0] old_load;
    logic              in_fire;
    logic              upd;
    logic              emit_fire;
    logic [PCT_W-1:0]  mul_pct;
    logic [PROD_W-1:0] mul_res;

    logic [DVS_W:0]    t0;
    logic [DVS_W:0]    t1;
    logic [DVS_W:0]    d0;
    logic [DVS_W:0]    d1;
    logic              q0;
    logic              q1;
    logic [DVS_W-1:0]  rem0;
    logic [DVS_W-1:0]  rem1;

    logic [LOAD_W-1:0] avg_q;
    logic [LOAD_W:0]   avg_mrg;
    logic              jump;
    logic [LOAD_EW-1:0] tgt_q;
    logic              lim;
    logic              busy_req;

    assign in_fire   = (i_ctl.op == OP_ACCEPT) && i_in_valid;
    assign upd       = (i_ctl.op == OP_UPDATE);
    assign emit_fire = (i_ctl.op == OP_EMIT) && !r_out_valid;
    assign old_load  = r_full ? ram_rdata : '0;

    lbfg_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (upd),
        .i_waddr (r_ptr),
        .i_wdata (r_load),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // one shared multiplier for the three percent thresholds
    always_comb begin
        unique case (i_ctl.op)
            OP_AVG_START: mul_pct = i_cfg.band_low_pct;
            OP_BAND_LO:   mul_pct = i_cfg.band_high_pct;
            default:      mul_pct = i_cfg.high_load_pct;
        endcase
        mul_res = PROD_W'(mul_pct) * PROD_W'(r_cur);
    end

    // two restoring division steps per cycle
    always_comb begin
        t0   = {r_rem, r_dvd[DVD_W-1]};
        d0   = t0 - {1'b0, r_dvs};
        q0   = (t0 >= {1'b0, r_dvs});
        rem0 = q0 ? d0[DVS_W-1:0] : t0[DVS_W-1:0];
        t1   = {rem0, r_dvd[DVD_W-2]};
        d1   = t1 - {1'b0, r_dvs};
        q1   = (t1 >= {1'b0, r_dvs});
        rem1 = q1 ? d1[DVS_W-1:0] : t1[DVS_W-1:0];
    end

    assign avg_q   = r_dvd[LOAD_W-1:0];
    assign avg_mrg = {1'b0, avg_q} + {1'b0, i_cfg.jump_margin};
    assign jump    = ({1'b0, r_load} > avg_mrg);
    assign tgt_q   = r_dvd[LOAD_EW-1:0];
    assign lim     = ((r_cur == i_cfg.max_freq) && (r_target >= {1'b0, i_cfg.max_freq}))
                  || ((r_cur == i_cfg.min_freq) && (r_target <= {1'b0, i_cfg.min_freq}));
    assign busy_req = (r_reason != RSN_BAND) && !lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd) begin
                r_sum <= r_sum + SUM_W'(r_load) - SUM_W'(old_load);
                if (r_ptr == PTR_W'(HISTORY_DEPTH - 1)) begin
                    r_ptr  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + PTR_W'(1);
                end
            end
            if (i_ctl.op == OP_AVG_START) begin
                r_cnt <= CNT_W'(DVD_W / 2);
            end else if (i_ctl.op == OP_DECIDE) begin
                r_cnt <= CNT_W'(LOAD_EW / 2);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_out_ready && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_load <= i_in_data.load_figure;
            r_cur  <= i_in_data.cur_freq;
        end
        if (upd || (i_ctl.op == OP_AVG_START) || (i_ctl.op == OP_BAND_LO)) begin
            r_prod <= mul_res;
        end
        if (i_ctl.op == OP_AVG_START) begin
            r_hi <= ({1'b0, r_load} > {1'b0, r_prod});
        end
        if (i_ctl.op == OP_BAND_LO) begin
            r_blo <= ({1'b0, r_load} > {1'b0, r_prod});
        end
        if (i_ctl.op == OP_BAND_HI) begin
            r_bhi <= ({1'b0, r_load} < {1'b0, r_prod});
        end
        if (i_ctl.op == OP_AVG_START) begin
            r_dvd <= DVD_W'(r_sum);
            r_dvs <= DVS_W'(HISTORY_DEPTH);
            r_rem <= '0;
        end else if (i_ctl.op == OP_DECIDE) begin
            r_dvd <= DVD_W'(r_load) << (DVD_W - LOAD_EW);
            r_dvs <= (i_cfg.target_pct == '0) ? DVS_W'(1) : i_cfg.target_pct;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-3:0], q0, q1};
            r_rem <= rem1;
        end
        if (i_ctl.op == OP_DECIDE) begin
            r_avg    <= avg_q;
            r_target <= {1'b0, i_cfg.max_freq};
            priority if (r_hi) begin
                r_reason <= RSN_HIGH;
            end else if (jump) begin
                r_reason <= RSN_JUMP;
            end else if (r_blo && r_bhi) begin
                r_reason <= RSN_BAND;
            end else begin
                r_reason <= RSN_CALC;
            end
        end
        if (i_ctl.op == OP_QUOT) begin
            r_target <= (|tgt_q[LOAD_EW-1:TGT_W]) ? TGT_MAX : tgt_q[TGT_W-1:0];
        end
        if (emit_fire) begin
            r_out.request_valid <= busy_req;
            r_out.target_freq   <= busy_req ? r_target : '0;
            r_out.via_bias      <= busy_req & i_cfg.bias_enable;
            r_out.average_load  <= r_avg;
            r_out.reason        <= ((r_reason != RSN_BAND) && lim) ? RSN_LIMIT : r_reason;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.div_busy = (r_cnt != '0);
    assign o_stat.not_calc = (r_reason != RSN_CALC);
    assign o_stat.out_full = r_out_valid;

endmodule

`default_nettype wire

### bench/tb_load_based_frequency_governor_unit.sv
// tb_load_based_frequency_governor_unit: self-checking bench for the governor, with
// a scoreboard class that predicts each decision and checks results in order
// depends on lbfg_pkg and load_based_frequency_governor_unit
`timescale 1ns / 1ps

module tb_load_based_frequency_governor_unit;
    import lbfg_pkg::*;

    localparam int HIST        = 10;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL        = 60;
    localparam int BATCH       = 280;

    class decision_scoreboard;
        t_cfg              cfg;
        logic [LOAD_W-1:0] ring [HIST];
        int unsigned       slot;
        longint unsigned   ring_sum;
        t_out              expected_decisions [$];
        int                errors;
        int                reports;

        function new();
            cfg = '{max_freq: 22'd1704000, min_freq: 22'd132000, bias_enable: 1'b0,
                    high_load_pct: 7'd95, jump_margin: 29'd9000000, band_low_pct: 7'd60,
                    band_high_pct: 7'd80, target_pct: 7'd65};
            foreach (ring[i]) ring[i] = '0;
            slot     = 0;
            ring_sum = 0;
            errors   = 0;
            reports  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_MAX_FREQ: cfg.max_freq      = v[FREQ_W-1:0];
                REG_MIN_FREQ: cfg.min_freq      = v[FREQ_W-1:0];
                REG_BIAS_EN:  cfg.bias_enable   = v[0];
                REG_HIGH_PCT: cfg.high_load_pct = v[PCT_W-1:0];
                REG_JUMP_MRG: cfg.jump_margin   = v[LOAD_W-1:0];
                REG_BAND_LO:  cfg.band_low_pct  = v[PCT_W-1:0];
                REG_BAND_HI:  cfg.band_high_pct = v[PCT_W-1:0];
                REG_TGT_PCT:  cfg.target_pct    = v[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_in s);
            longint unsigned load, cur, avg, tgt, hp, lo, hi, tp, mx, mn, mrg;
            t_reason         why;
            logic            req;
            t_out            e;
            load = s.load_figure;
            cur  = s.cur_freq;
            hp   = cfg.high_load_pct;
            lo   = cfg.band_low_pct;
            hi   = cfg.band_high_pct;
            tp   = cfg.target_pct;
            mx   = cfg.max_freq;
            mn   = cfg.min_freq;
            mrg  = cfg.jump_margin;
            ring_sum   = ring_sum + load - ring[slot];
            ring[slot] = s.load_figure;
            slot       = (slot + 1) % HIST;
            avg        = ring_sum / HIST;
            tgt        = 0;
            if (load > hp * cur) begin
                tgt = mx;
                why = RSN_HIGH;
            end else if (load > avg + mrg) begin
                tgt = mx;
                why = RSN_JUMP;
            end else if (load > lo * cur && load < hi * cur) begin
                why = RSN_BAND;
            end else begin
                tgt = load / ((tp == 0) ? 1 : tp);
                if (tgt > TGT_MAX) begin
                    tgt = TGT_MAX;
                end
                why = RSN_CALC;
            end
            req = (why != RSN_BAND);
            if (req && ((cur == mx && tgt >= mx) || (cur == mn && tgt <= mn))) begin
                req = 1'b0;
                why = RSN_LIMIT;
            end
            e.request_valid = req;
            e.target_freq   = req ? tgt[TGT_W-1:0] : '0;
            e.via_bias      = req & cfg.bias_enable;
            e.average_load  = avg[LOAD_W-1:0];
            e.reason        = why;
            expected_decisions.push_back(e);
        endfunction

        function void check_decision(t_out got);
            t_out e;
            if (expected_decisions.size() == 0) begin
                errors++;
                reports++;
                if (reports <= 10) begin
                    $display("unexpected result: valid=%0d target=%0d bias=%0d avg=%0d reason=%0d",
                             got.request_valid, got.target_freq, got.via_bias,
                             got.average_load, got.reason);
                end
                return;
            end
            e = expected_decisions.pop_front();
            if (got.request_valid !== e.request_valid || got.target_freq !== e.target_freq ||
                got.via_bias !== e.via_bias || got.average_load !== e.average_load ||
                got.reason !== e.reason) begin
                errors++;
                reports++;
                if (reports <= 10) begin
                    $display("mismatch: exp valid=%0d target=%0d bias=%0d avg=%0d reason=%0d",
                             e.request_valid, e.target_freq, e.via_bias,
                             e.average_load, e.reason);
                    $display("          got valid=%0d target=%0d bias=%0d avg=%0d reason=%0d",
                             got.request_valid, got.target_freq, got.via_bias,
                             got.average_load, got.reason);
                end
            end
        endfunction

        function int pending();
            return expected_decisions.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    decision_scoreboard sb;
    bit                 hold_req;
    int                 cycles;

    load_based_frequency_governor_unit #(
        .HISTORY_DEPTH(HIST)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            sb.check_decision(o_out_data);
        end
    end

    // receiver: free runs, random stalls, short stall bursts, one long hold-off on request
    initial begin
        int n;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0: begin
                        i_out_ready <= 1'b1;
                        repeat (n) @(posedge i_clk);
                    end
                    1: begin
                        repeat (n) begin
                            i_out_ready <= ($urandom_range(0, 3) != 0);
                            @(posedge i_clk);
                        end
                    end
                    default: begin
                        i_out_ready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                        i_out_ready <= 1'b1;
                        repeat ($urandom_range(1, 5)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    function automatic t_in sample(longint unsigned load, longint unsigned freq);
        t_in s;
        s.load_figure = load[LOAD_W-1:0];
        s.cur_freq    = freq[FREQ_W-1:0];
        return s;
    endfunction

    // samples cluster around the thresholds so every decision path is taken
    function automatic t_in make_sample();
        longint unsigned f, l;
        int unsigned     pct;
        case ($urandom_range(0, 9))
            0:       f = sb.cfg.max_freq;
            1:       f = sb.cfg.min_freq;
            2:       f = $urandom_range(0, 2000);
            3:       f = $urandom & 32'h3FFFFF;
            default: f = $urandom_range(100000, 2500000);
        endcase
        case ($urandom_range(0, 9))
            0: l = $urandom & 32'h1FFFFFFF;
            1: l = 0;
            2: l = 32'h1FFFFFFF;
            default: begin
                case ($urandom_range(0, 4))
                    0:       pct = sb.cfg.high_load_pct;
                    1:       pct = sb.cfg.band_low_pct;
                    2:       pct = sb.cfg.band_high_pct;
                    default: pct = $urandom_range(0, 127);
                endcase
                l = pct * f;
                case ($urandom_range(0, 2))
                    0:       l = (l > 0) ? l - 1 : 0;
                    1:       l = l + 1;
                    default: ;
                endcase
                if (l > 32'h1FFFFFFF) begin
                    l = 32'h1FFFFFFF;
                end
            end
        endcase
        return sample(l, f);
    endfunction

    task automatic send_one(t_in s);
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(s);
    endtask

    task automatic send_batch(int n);
        int left, burst, gap;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) begin
                send_one(make_sample());
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
    endtask

    task automatic apply_config(t_cfg c);
        apb_write(REG_MAX_FREQ, 32'(c.max_freq));
        apb_write(REG_MIN_FREQ, 32'(c.min_freq));
        apb_write(REG_BIAS_EN,  32'(c.bias_enable));
        apb_write(REG_HIGH_PCT, 32'(c.high_load_pct));
        apb_write(REG_JUMP_MRG, 32'(c.jump_margin));
        apb_write(REG_BAND_LO,  32'(c.band_low_pct));
        apb_write(REG_BAND_HI,  32'(c.band_high_pct));
        apb_write(REG_TGT_PCT,  32'(c.target_pct));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_cfg c;
        sb         = new();
        hold_req   = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every decision path at the field extremes
        send_one(sample(0, 0));
        send_one(sample(29'h1FFFFFFF, 22'h3FFFFF));
        send_one(sample(29'h1FFFFFFF, 0));
        send_one(sample(96000000, 1000000));
        send_one(sample(95000000, 1000000));
        send_one(sample(70000, 1000));
        send_one(sample(60000, 1000));
        send_one(sample(80000, 1000));
        send_one(sample(180000000, 2000000));
        send_one(sample(99 * 1704000, 1704000));
        send_one(sample(10 * 132000, 132000));
        send_one(sample(0, 22'h3FFFFF));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        send_batch(BATCH);
        wait_drain();

        c = '{max_freq: 22'h3FFFFF, min_freq: 22'd0, bias_enable: 1'b1,
              high_load_pct: 7'd100, jump_margin: 29'd0, band_low_pct: 7'd0,
              band_high_pct: 7'd100, target_pct: 7'd1};
        apply_config(c);
        send_one(sample(29'h1FFFFFFF, 22'h3FFFFF));
        send_one(sample(0, 0));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        send_batch(BATCH);
        wait_drain();

        // divisor of zero, percents above a hundred, saturated target
        c = '{max_freq: 22'd0, min_freq: 22'h3FFFFF, bias_enable: 1'b1,
              high_load_pct: 7'd127, jump_margin: 29'h1FFFFFFF, band_low_pct: 7'd0,
              band_high_pct: 7'd0, target_pct: 7'd0};
        apply_config(c);
        send_one(sample(532676481, 22'h3FFFFF));
        send_one(sample(5000, 22'h3FFFFF));
        send_one(sample(0, 0));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        send_batch(BATCH);
        wait_drain();

        c = '{max_freq: 22'd1200000, min_freq: 22'd300000, bias_enable: 1'b0,
              high_load_pct: 7'd1, jump_margin: 29'd1000000, band_low_pct: 7'd90,
              band_high_pct: 7'd95, target_pct: 7'd100};
        apply_config(c);
        send_batch(BATCH);
        wait_drain();

        repeat (2) begin
            c.max_freq      = FREQ_W'($urandom);
            c.min_freq      = FREQ_W'($urandom);
            c.bias_enable   = 1'($urandom);
            c.high_load_pct = PCT_W'($urandom_range(1, 127));
            c.jump_margin   = LOAD_W'($urandom_range(0, 50000000));
            c.band_low_pct  = PCT_W'($urandom_range(0, 127));
            c.band_high_pct = PCT_W'($urandom_range(0, 127));
            c.target_pct    = PCT_W'($urandom_range(0, 127));
            apply_config(c);
            send_batch(BATCH);
            wait_drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
